[src/gdt_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the graph walker.
`default_nettype none
package gdt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = MAX_VERTICES;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int VID_W        = 6;
    localparam int VCNT_W       = 7;

    localparam logic [VCNT_W-1:0] NO_VERTEX = VCNT_W'(64);

    // Command opcodes on the input beat
    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_DFS      = 2'd2;
    localparam logic [1:0] OP_BFS      = 2'd3;

    // Datapath micro-operations
    typedef logic [3:0] t_dp_op;
    localparam t_dp_op DP_NOP       = 4'd0;
    localparam t_dp_op DP_LOAD      = 4'd1;
    localparam t_dp_op DP_RD_A      = 4'd2;
    localparam t_dp_op DP_WR_A      = 4'd3;
    localparam t_dp_op DP_RD_B      = 4'd4;
    localparam t_dp_op DP_WR_B      = 4'd5;
    localparam t_dp_op DP_DEL       = 4'd6;
    localparam t_dp_op DP_ROOT_SKIP = 4'd7;
    localparam t_dp_op DP_ROOT_VIS  = 4'd8;
    localparam t_dp_op DP_RD_CUR    = 4'd9;
    localparam t_dp_op DP_LOAD_CAND = 4'd10;
    localparam t_dp_op DP_TAKE      = 4'd11;
    localparam t_dp_op DP_POP       = 4'd12;
    localparam t_dp_op DP_DEQ       = 4'd13;
    localparam t_dp_op DP_CUR_STORE = 4'd14;
    localparam t_dp_op DP_FINISH    = 4'd15;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic root_end;
        logic root_skip;
        logic cand_nz;
        logic wptr_one;
        logic q_empty;
    } t_dp_stat;

endpackage
`default_nettype wire

[src/graph_dfs_bfs_traversal_core.sv]
// Top level of the graph walker: controller plus datapath.
// Add edge and delete return no results.
// Walk: root ids are scanned in ascending order, and a depth-first or breadth-first
// walk runs from each root that is neither visited nor deleted.
// A result beat shows for one cycle, in the cycle after the next vertex is found or the
// walk ends. One command at a time. Synchronous active-low reset empties the graph.
`default_nettype none
module graph_dfs_bfs_traversal_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_op,
    input  wire logic [gdt_pkg::VID_W-1:0]  i_first_vertex,
    input  wire logic [gdt_pkg::VID_W-1:0]  i_second_vertex,
    input  wire logic                       i_cfg_we,
    input  wire logic [gdt_pkg::VCNT_W-1:0] i_cfg_wdata,
    output logic                            o_valid,
    output logic [gdt_pkg::VID_W-1:0]       o_visited_vertex,
    output logic                            o_last
);
    import gdt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    gdt_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_first_vertex   (i_first_vertex),
        .i_second_vertex  (i_second_vertex),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_visited_vertex (o_visited_vertex),
        .o_last           (o_last)
    );
endmodule
`default_nettype wire

[src/gdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/gdt_ctrl.sv]
// Controller state machine: sequences edge updates, deletes and the two walks.
`default_nettype none
module gdt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_op,
    input  wire gdt_pkg::t_dp_stat i_stat,
    output logic                  busy,
    output gdt_pkg::t_dp_cmd      o_cmd
);
    import gdt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_WRA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_WRB   = 4'd4;
    localparam logic [3:0] S_DEL   = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_LD    = 4'd8;
    localparam logic [3:0] S_DCHK  = 4'd9;
    localparam logic [3:0] S_DCUR  = 4'd10;
    localparam logic [3:0] S_BSCAN = 4'd11;
    localparam logic [3:0] S_DEQ   = 4'd12;
    localparam logic [3:0] S_BCUR  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_bfs, n_bfs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bfs   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bfs   <= n_bfs;
        end
    end

    assign busy = (r_state != S_IDLE);

    // Next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_bfs    = r_bfs;
        o_cmd.op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LOAD;
                    n_bfs    = (i_op == OP_BFS);
                    case (i_op)
                        OP_ADD_EDGE: n_state = S_RDA;
                        OP_DELETE:   n_state = S_DEL;
                        default:     n_state = S_ROOT;
                    endcase
                end
            end
            S_RDA: begin
                o_cmd.op = DP_RD_A;
                n_state  = S_WRA;
            end
            S_WRA: begin
                o_cmd.op = DP_WR_A;
                n_state  = S_RDB;
            end
            S_RDB: begin
                o_cmd.op = DP_RD_B;
                n_state  = S_WRB;
            end
            S_WRB: begin
                o_cmd.op = DP_WR_B;
                n_state  = S_IDLE;
            end
            S_DEL: begin
                o_cmd.op = DP_DEL;
                n_state  = S_IDLE;
            end
            // Root scan in ascending id
            S_ROOT: begin
                if (i_stat.root_end) begin
                    n_state = S_FIN;
                end else if (i_stat.root_skip) begin
                    o_cmd.op = DP_ROOT_SKIP;
                end else begin
                    o_cmd.op = DP_ROOT_VIS;
                    n_state  = r_bfs ? S_DEQ : S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = DP_RD_CUR;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.op = DP_LOAD_CAND;
                n_state  = r_bfs ? S_BSCAN : S_DCHK;
            end
            // Depth-first: descend on the lowest fresh neighbor, else backtrack
            S_DCHK: begin
                if (i_stat.cand_nz) begin
                    o_cmd.op = DP_TAKE;
                    n_state  = S_RD;
                end else begin
                    o_cmd.op = DP_POP;
                    n_state  = i_stat.wptr_one ? S_ROOT : S_DCUR;
                end
            end
            S_DCUR: begin
                o_cmd.op = DP_CUR_STORE;
                n_state  = S_RD;
            end
            // Breadth-first: enqueue all fresh neighbors, then dequeue
            S_BSCAN: begin
                if (i_stat.cand_nz) begin
                    o_cmd.op = DP_TAKE;
                end else begin
                    n_state = S_DEQ;
                end
            end
            S_DEQ: begin
                if (i_stat.q_empty) begin
                    n_state = S_ROOT;
                end else begin
                    o_cmd.op = DP_DEQ;
                    n_state  = S_BCUR;
                end
            end
            S_BCUR: begin
                o_cmd.op = DP_CUR_STORE;
                n_state  = S_RD;
            end
            S_FIN: begin
                o_cmd.op = DP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[src/gdt_dpath.sv]
// Datapath: adjacency memory, visited map, stack/queue store and result register.
`default_nettype none
module gdt_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [gdt_pkg::VID_W-1:0]  i_first_vertex,
    input  wire logic [gdt_pkg::VID_W-1:0]  i_second_vertex,
    input  wire logic                       i_cfg_we,
    input  wire logic [gdt_pkg::VCNT_W-1:0] i_cfg_wdata,
    input  wire gdt_pkg::t_dp_cmd           i_cmd,
    output gdt_pkg::t_dp_stat               o_stat,
    output logic                            o_valid,
    output logic [gdt_pkg::VID_W-1:0]       o_visited_vertex,
    output logic                            o_last
);
    import gdt_pkg::*;

    // Lowest set bit index: isolate it, then encode
    function automatic logic [VID_W-1:0] f_lowest(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] iso;
        logic [VID_W-1:0] idx;
        iso = v & (~v + ROW_W'(1));
        idx = '0;
        for (int k = 0; k < ROW_W; k++) begin
            if (iso[k]) begin
                idx = idx | VID_W'(k);
            end
        end
        return idx;
    endfunction

    logic [VID_W-1:0]  r_a, r_b, r_cur, r_pend, r_out_vtx;
    logic [VCNT_W-1:0] r_vcount, r_deleted, r_root, r_wptr, r_front;
    logic [ROW_W-1:0]  r_visited, r_cand, r_adj_valid;
    logic              r_rd_valid, r_pend_v, r_out_v, r_out_last;

    logic [ADDR_W-1:0] adj_raddr, adj_waddr, st_raddr;
    logic [ROW_W-1:0]  adj_rdata, adj_wdata, row, delmask;
    logic              adj_we, a_ok, b_ok;
    logic [VID_W-1:0]  st_rdata, take_v, emit_v;
    logic              emit_now, st_we;
    logic [VCNT_W-1:0] roots, wptr_m2;

    assign a_ok    = ({1'b0, r_a} < VCNT_W'(MAX_VERTICES));
    assign b_ok    = ({1'b0, r_b} < VCNT_W'(MAX_VERTICES));
    assign row     = r_rd_valid ? adj_rdata : '0;
    assign delmask = (r_deleted < VCNT_W'(MAX_VERTICES)) ?
                     (ROW_W'(1) << r_deleted[VID_W-1:0]) : '0;
    assign take_v  = f_lowest(r_cand);
    assign roots   = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcount;
    assign wptr_m2 = r_wptr - VCNT_W'(2);

    // Status back to the controller
    assign o_stat.root_end  = (r_root >= roots);
    assign o_stat.root_skip = (r_root == r_deleted) || r_visited[r_root[ADDR_W-1:0]];
    assign o_stat.cand_nz   = |r_cand;
    assign o_stat.wptr_one  = (r_wptr == VCNT_W'(1));
    assign o_stat.q_empty   = (r_front == r_wptr);

    // Adjacency port steering
    always_comb begin
        adj_raddr = r_cur[ADDR_W-1:0];
        adj_waddr = r_a[ADDR_W-1:0];
        adj_wdata = row | (ROW_W'(1) << r_b);
        adj_we    = 1'b0;
        case (i_cmd.op)
            DP_RD_A: adj_raddr = r_a[ADDR_W-1:0];
            DP_RD_B: adj_raddr = r_b[ADDR_W-1:0];
            DP_WR_A: adj_we = a_ok && b_ok;
            DP_WR_B: begin
                adj_waddr = r_b[ADDR_W-1:0];
                adj_wdata = row | (ROW_W'(1) << r_a);
                adj_we    = a_ok && b_ok;
            end
            DP_DEL: begin
                adj_wdata = '0;
                adj_we    = a_ok;
            end
            default: ;
        endcase
    end

    // Stack/queue store steering and emit select
    assign st_raddr = (i_cmd.op == DP_DEQ) ? r_front[ADDR_W-1:0] : wptr_m2[ADDR_W-1:0];
    assign emit_now = (i_cmd.op == DP_ROOT_VIS) || (i_cmd.op == DP_TAKE);
    assign emit_v   = (i_cmd.op == DP_TAKE) ? take_v : r_root[VID_W-1:0];
    assign st_we    = emit_now;

    gdt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gdt_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_wptr[ADDR_W-1:0]),
        .i_wdata (emit_v),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_adj_valid[adj_raddr];
        if (i_cmd.op == DP_LOAD) begin
            r_a <= i_first_vertex;
            r_b <= i_second_vertex;
        end
        case (i_cmd.op)
            DP_ROOT_VIS:  r_cur <= r_root[VID_W-1:0];
            DP_TAKE:      r_cur <= take_v;
            DP_CUR_STORE: r_cur <= st_rdata;
            default: ;
        endcase
        if (i_cmd.op == DP_LOAD_CAND) begin
            r_cand <= row & ~r_visited & ~delmask;
        end else if (i_cmd.op == DP_TAKE) begin
            r_cand <= r_cand & ~(ROW_W'(1) << take_v);
        end
        if (emit_now) begin
            r_pend <= emit_v;
        end
        r_out_vtx  <= r_pend;
        // an empty walk has no pending vertex, so no last flag either
        r_out_last <= (i_cmd.op == DP_FINISH) && r_pend_v;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= '0;
            r_deleted   <= NO_VERTEX;
            r_adj_valid <= '0;
            r_visited   <= '0;
            r_root      <= '0;
            r_wptr      <= '0;
            r_front     <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (adj_we) begin
                r_adj_valid[adj_waddr] <= 1'b1;
            end
            if (i_cmd.op == DP_DEL && a_ok) begin
                r_deleted <= {1'b0, r_a};
            end
            // the previous pending vertex goes out whenever a new one arrives
            r_out_v <= (emit_now || (i_cmd.op == DP_FINISH)) && r_pend_v;
            if (emit_now) begin
                r_pend_v <= 1'b1;
            end
            case (i_cmd.op)
                DP_LOAD: begin
                    r_visited <= '0;
                    r_root    <= '0;
                    r_wptr    <= '0;
                    r_front   <= '0;
                    r_pend_v  <= 1'b0;
                end
                DP_ROOT_SKIP: r_root <= r_root + VCNT_W'(1);
                DP_ROOT_VIS: begin
                    r_visited <= r_visited | (ROW_W'(1) << r_root[VID_W-1:0]);
                    r_wptr    <= r_wptr + VCNT_W'(1);
                end
                DP_TAKE: begin
                    r_visited <= r_visited | (ROW_W'(1) << take_v);
                    r_wptr    <= r_wptr + VCNT_W'(1);
                end
                DP_POP:    r_wptr   <= r_wptr - VCNT_W'(1);
                DP_DEQ:    r_front  <= r_front + VCNT_W'(1);
                DP_FINISH: r_pend_v <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_out_v;
    assign o_visited_vertex = r_out_vtx;
    assign o_last           = r_out_last;
endmodule
`default_nettype wire

[src/gdt_chk.sv]
// Port-level checker for the graph walker and its bind to the top level.
`default_nettype none
module gdt_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_op,
    input wire logic       o_valid,
    input wire logic       o_last
);
    import gdt_pkg::*;

    // results only come out of work started earlier
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a running command");

    // the final beat closes the walk
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("last beat while still busy");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without a beat");

    // accepting a command never produces a beat in the next cycle
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("beat right after command accept");

    // edits keep the block busy
    a_edit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_ADD_EDGE || i_op == OP_DELETE)) |=> busy)
        else $error("edit command not taken");
endmodule

bind graph_dfs_bfs_traversal_core gdt_chk u_gdt_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_op    (i_op),
    .o_valid (o_valid),
    .o_last  (o_last)
);
`default_nettype wire
